// ===== src/cbe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_pkg: shared types and helpers for the C-style byte escaper
// Character codes, the escape run record and the escape decoder.
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int unsigned MaxRun = 4;
    localparam int unsigned IdxW   = $clog2(MaxRun);

    typedef logic [7:0] byte_t;

    localparam byte_t ChSpace     = 8'h20;
    localparam byte_t ChTilde     = 8'h7E;
    localparam byte_t ChSquote    = 8'h27;
    localparam byte_t ChDquote    = 8'h22;
    localparam byte_t ChBackslash = 8'h5C;
    localparam byte_t ChNul       = 8'h00;
    localparam byte_t ChBell      = 8'h07;
    localparam byte_t ChBackspace = 8'h08;
    localparam byte_t ChTab       = 8'h09;
    localparam byte_t ChNewline   = 8'h0A;
    localparam byte_t ChVtab      = 8'h0B;
    localparam byte_t ChFormfeed  = 8'h0C;
    localparam byte_t ChReturn    = 8'h0D;
    localparam byte_t ChDigit0    = 8'h30;
    localparam byte_t ChLowerA    = 8'h61;
    localparam byte_t ChLowerB    = 8'h62;
    localparam byte_t ChLowerF    = 8'h66;
    localparam byte_t ChLowerN    = 8'h6E;
    localparam byte_t ChLowerR    = 8'h72;
    localparam byte_t ChLowerT    = 8'h74;
    localparam byte_t ChLowerV    = 8'h76;
    localparam byte_t ChLowerX    = 8'h78;

    // Index of the last byte of a run: runs are one, two or four bytes long
    localparam logic [IdxW-1:0] LastOfOne  = IdxW'(0);
    localparam logic [IdxW-1:0] LastOfTwo  = IdxW'(1);
    localparam logic [IdxW-1:0] LastOfFour = IdxW'(3);

    typedef struct packed {
        byte_t [MaxRun-1:0] seq;
        logic  [IdxW-1:0]   last_idx;
    } esc_run_t;

    // Lower-case hex digit for one nibble
    function automatic byte_t hex_digit(input logic [3:0] nib);
        byte_t digit;
        if (nib < 4'd10)
        begin
            digit = ChDigit0 + {4'h0, nib};
        end
        else
        begin
            digit = ChLowerA - 8'd10 + {4'h0, nib};
        end
        return digit;
    endfunction

    // Build the whole escaped run for one raw byte
    function automatic esc_run_t escape_byte(input byte_t c);
        esc_run_t run;
        byte_t    second;
        logic     has_short;
        has_short = 1'b1;
        second    = ChNul;
        unique case (c)
            ChSquote:    second = ChSquote;
            ChDquote:    second = ChDquote;
            ChBackslash: second = ChBackslash;
            ChBell:      second = ChLowerA;
            ChBackspace: second = ChLowerB;
            ChFormfeed:  second = ChLowerF;
            ChNewline:   second = ChLowerN;
            ChReturn:    second = ChLowerR;
            ChTab:       second = ChLowerT;
            ChVtab:      second = ChLowerV;
            ChNul:       second = ChDigit0;
            default:     has_short = 1'b0;
        endcase

        run.seq = '0;
        if (c >= ChSpace && c <= ChTilde && !has_short)
        begin
            run.seq[0]   = c;
            run.last_idx = LastOfOne;
        end
        else if (has_short)
        begin
            run.seq[0]   = ChBackslash;
            run.seq[1]   = second;
            run.last_idx = LastOfTwo;
        end
        else
        begin
            run.seq[0]   = ChBackslash;
            run.seq[1]   = ChLowerX;
            run.seq[2]   = hex_digit(c[7:4]);
            run.seq[3]   = hex_digit(c[3:0]);
            run.last_idx = LastOfFour;
        end
        return run;
    endfunction

endpackage
`default_nettype wire

// ===== src/cbe_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_stream_if: request channels of the C-style byte escaper
// Raw byte channel in, escaped byte channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbe_in_if import cbe_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t raw_byte;
    logic  string_end;

    modport source (output valid, raw_byte, string_end, input ready);
    modport sink   (input valid, raw_byte, string_end, output ready);
endinterface

interface cbe_out_if import cbe_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  run_last;
    logic  string_done;

    modport source (output valid, out_byte, run_last, string_done, input ready);
    modport sink   (input valid, out_byte, run_last, string_done, output ready);
endinterface
`default_nettype wire

// ===== src/c_style_byte_escaper_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c_style_byte_escaper_top: C string literal escaper, one byte per request
// Path: the raw byte is decoded into the run register, and each escaped byte
// then passes through the output register before the sink takes it.
// Throughput: one output byte per cycle while the sink is ready. A raw byte
// fills the run register with 1, 2 or 4 bytes (plain, short, hex escape); the
// next raw byte is taken in the same cycle the last byte of a run moves out.
// Reset: rst_n clears the run and output valid flags and the run index.
// ----------------------------------------------------------------------------
module c_style_byte_escaper_top import cbe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cbe_in_if.sink     byte_in,
    cbe_out_if.source  esc_out
);

    // Run register: the escaped run of the current raw byte and its progress
    logic              item_valid_reg;
    logic              item_valid_next;
    logic [IdxW-1:0]   idx_reg;
    logic [IdxW-1:0]   idx_next;
    esc_run_t          run_reg;
    logic              end_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    byte_t             out_byte_reg;
    logic              run_last_reg;
    logic              done_reg;

    logic              out_load;
    logic              emit;
    logic              run_end;
    logic              accept;

    // The output register can load when empty or when its byte is taken
    assign out_load = !out_valid_reg || esc_out.ready;
    // Advance the run by one byte whenever the output register loads
    assign emit     = item_valid_reg && out_load;
    assign run_end  = (idx_reg == run_reg.last_idx);

    // Take a new raw byte when the run register is empty or drains this cycle
    assign byte_in.ready = !item_valid_reg || (emit && run_end);
    assign accept        = byte_in.valid && byte_in.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        idx_next        = idx_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
            idx_next        = '0;
        end
        else if (emit)
        begin
            item_valid_next = !run_end;
            idx_next        = idx_reg + IdxW'(1);
        end
    end

    assign out_valid_next = out_load ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload: decode at the input, one byte per cycle while the output loads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            run_reg <= escape_byte(byte_in.raw_byte);
            end_reg <= byte_in.string_end;
        end
        if (emit)
        begin
            out_byte_reg <= run_reg.seq[idx_reg];
            run_last_reg <= run_end;
            done_reg     <= run_end && end_reg;
        end
    end

    assign esc_out.valid       = out_valid_reg;
    assign esc_out.out_byte    = out_byte_reg;
    assign esc_out.run_last    = run_last_reg;
    assign esc_out.string_done = done_reg;

    // A finished string always closes a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> run_last_reg)
        else $error("string_done without run_last");

    // The run index never passes the end of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> idx_reg <= run_reg.last_idx)
        else $error("run index past end of run");

    // A new raw byte is never taken while a run still has bytes to send
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_valid_reg |-> emit && run_end)
        else $error("raw byte taken over an unfinished run");

    // A run that sent a middle byte keeps its register
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && !run_end |=> item_valid_reg && idx_reg == $past(idx_reg) + IdxW'(1))
        else $error("run dropped before its last byte");

endmodule
`default_nettype wire
